// ===== design/sst_pkg.sv =====
// ----------------------------------------------------------------------------
// sst_pkg: shared types and codes for the bounded set span tracker
// Request and result payloads, op and status codes, fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package sst_pkg;

  // Fixed field widths
  localparam int unsigned FIELD_W = 32;
  localparam int unsigned SPAN_W  = 32;
  localparam int unsigned CAP_W   = 6;
  localparam int unsigned STAT_W  = 2;

  // Request op codes
  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_CLEAR = 1'b1
  } op_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Input request payload
  typedef struct packed {
    op_t                        op;
    logic signed [FIELD_W-1:0]  value;
  } in_req_t;

  // Result payload
  typedef struct packed {
    status_t              status;
    logic [CAP_W-1:0]     held_count;
    logic [SPAN_W-1:0]    shortest_span;
    logic [SPAN_W-1:0]    longest_span;
  } out_rsp_t;

endpackage

`default_nettype wire

// ===== design/sst_cell.sv =====
// ----------------------------------------------------------------------------
// sst_cell: one storage cell of the span tracker chain
// Holds one set value and, if live, folds the distance to a passing probe
// value into the probe's running minimum gap, then hands it to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_cell #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned CNT_W      = 6,
  parameter int unsigned INDEX      = 0
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [CNT_W-1:0]              count_i,
  input  wire logic                          commit_i,
  input  wire logic signed [VALUE_BITS-1:0]  wr_val_i,
  input  wire logic                          tok_vld_i,
  input  wire logic signed [VALUE_BITS-1:0]  tok_val_i,
  input  wire logic [sst_pkg::SPAN_W-1:0]    tok_min_i,
  output logic                               tok_vld_o,
  output logic signed [VALUE_BITS-1:0]       tok_val_o,
  output logic [sst_pkg::SPAN_W-1:0]         tok_min_o
);
  import sst_pkg::*;

  logic signed [VALUE_BITS-1:0]  held_r;
  logic                          tok_vld_r;
  logic signed [VALUE_BITS-1:0]  tok_val_r;
  logic [SPAN_W-1:0]             tok_min_r;
  logic [SPAN_W-1:0]             tok_min_nxt;
  logic                          held_ok;
  logic signed [VALUE_BITS:0]    diff;
  logic [VALUE_BITS-1:0]         mag;
  logic [SPAN_W-1:0]             gap;

  // Cell holds a live value when its slot is below the fill count
  assign held_ok = count_i > CNT_W'(INDEX);

  // Distance from probe to held value
  always_comb begin
    diff = {tok_val_i[VALUE_BITS-1], tok_val_i} - {held_r[VALUE_BITS-1], held_r};
    if (diff[VALUE_BITS]) begin
      mag = VALUE_BITS'(-diff);
    end else begin
      mag = diff[VALUE_BITS-1:0];
    end
    gap = SPAN_W'(mag);
  end

  // Fold into running minimum
  always_comb begin
    tok_min_nxt = tok_min_i;
    if (held_ok && (gap < tok_min_i)) begin
      tok_min_nxt = gap;
    end
  end

  // Probe stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_vld_r <= 1'b0;
    end else begin
      tok_vld_r <= tok_vld_i;
    end
  end

  always_ff @(posedge clk) begin
    tok_val_r <= tok_val_i;
    tok_min_r <= tok_min_nxt;
  end

  // Stored value: written when the insert commits to this slot
  always_ff @(posedge clk) begin
    if (commit_i && (count_i == CNT_W'(INDEX))) begin
      held_r <= wr_val_i;
    end
  end

  assign tok_vld_o = tok_vld_r;
  assign tok_val_o = tok_val_r;
  assign tok_min_o = tok_min_r;

endmodule

`default_nettype wire

// ===== design/bounded_set_span_tracker.sv =====
// ----------------------------------------------------------------------------
// bounded_set_span_tracker: bounded value set with longest/shortest span
// Clear and dropped (full) requests: result strobe in the next cycle, one
// request per cycle. Add: the probe walks the DEPTH-cell chain one cell per
// cycle; once the probe leaves the last cell the result is registered and
// strobes. Busy is high while the probe walks and low in the result's cycle,
// so the next request can be taken then. Results cannot be stalled.
// Synchronous active-low reset empties the set and zeroes the capacity
// register; the value cells are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_set_span_tracker #(
  parameter int unsigned DEPTH      = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Request channel
  input  wire logic                          start,
  output logic                               busy,
  input  wire sst_pkg::in_req_t              in_req,
  // Result channel
  output logic                               out_valid,
  output sst_pkg::out_rsp_t                  out_rsp,
  // Configuration channel
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [sst_pkg::CAP_W-1:0]     cfg_data
);
  import sst_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } state_t;

  state_t                        state_r, state_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [SPAN_W-1:0]             gap_r, gap_nxt;
  logic signed [VALUE_BITS-1:0]  lo_r, lo_nxt;
  logic signed [VALUE_BITS-1:0]  hi_r, hi_nxt;
  logic [CAP_W-1:0]              cap_r;
  logic                          out_valid_r, out_valid_nxt;
  status_t                       status_r, status_nxt;

  logic                          accept;
  logic                          inject;
  logic                          commit;
  logic                          full;
  logic [LIM_W-1:0]              limit;
  logic signed [VALUE_BITS-1:0]  in_val;
  logic signed [VALUE_BITS-1:0]  new_val;
  logic [SPAN_W-1:0]             new_gap;
  logic signed [VALUE_BITS:0]    span_full;

  logic [DEPTH-1:0]              tok_vld;
  logic signed [VALUE_BITS-1:0]  tok_val [DEPTH];
  logic [SPAN_W-1:0]             tok_min [DEPTH];

  localparam logic signed [VALUE_BITS-1:0] LO_INIT = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] HI_INIT = {1'b1, {(VALUE_BITS-1){1'b0}}};

  // Handshakes
  assign busy      = (state_r == S_WALK);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // Effective capacity saturates at DEPTH
  always_comb begin
    limit = LIM_W'(cap_r);
    if (limit > LIM_W'(DEPTH)) begin
      limit = LIM_W'(DEPTH);
    end
  end
  assign full   = LIM_W'(count_r) >= limit;
  assign in_val = in_req.value[VALUE_BITS-1:0];
  assign inject = accept && (in_req.op == OP_ADD) && !full;

  // Probe leaving the last cell carries the folded minimum
  assign commit  = tok_vld[DEPTH-1];
  assign new_val = tok_val[DEPTH-1];
  assign new_gap = tok_min[DEPTH-1];

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      sst_cell #(
        .VALUE_BITS (VALUE_BITS),
        .CNT_W      (CNT_W),
        .INDEX      (i)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .count_i   (count_r),
        .commit_i  (commit),
        .wr_val_i  (new_val),
        .tok_vld_i (inject),
        .tok_val_i (in_val),
        .tok_min_i (gap_r),
        .tok_vld_o (tok_vld[i]),
        .tok_val_o (tok_val[i]),
        .tok_min_o (tok_min[i])
      );
    end else begin : g_body
      sst_cell #(
        .VALUE_BITS (VALUE_BITS),
        .CNT_W      (CNT_W),
        .INDEX      (i)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .count_i   (count_r),
        .commit_i  (commit),
        .wr_val_i  (new_val),
        .tok_vld_i (tok_vld[i-1]),
        .tok_val_i (tok_val[i-1]),
        .tok_min_i (tok_min[i-1]),
        .tok_vld_o (tok_vld[i]),
        .tok_val_o (tok_val[i]),
        .tok_min_o (tok_min[i])
      );
    end
  end

  // Control and set state
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    gap_nxt       = gap_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_req.op == OP_CLEAR) begin
            count_nxt     = '0;
            gap_nxt       = '1;
            lo_nxt        = LO_INIT;
            hi_nxt        = HI_INIT;
            status_nxt    = ST_SHORT;
            out_valid_nxt = 1'b1;
          end else if (full) begin
            status_nxt    = ST_FULL;
            out_valid_nxt = 1'b1;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (commit) begin
          count_nxt     = count_r + CNT_W'(1);
          gap_nxt       = new_gap;
          if (new_val < lo_r) begin
            lo_nxt = new_val;
          end
          if (new_val > hi_r) begin
            hi_nxt = new_val;
          end
          status_nxt    = (count_r == '0) ? ST_SHORT : ST_OK;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      gap_r       <= '1;
      lo_r        <= LO_INIT;
      hi_r        <= HI_INIT;
      out_valid_r <= 1'b0;
      status_r    <= ST_SHORT;
      cap_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      gap_r       <= gap_nxt;
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
    end
  end

  // Result fields from current set state
  assign span_full = {hi_r[VALUE_BITS-1], hi_r} - {lo_r[VALUE_BITS-1], lo_r};

  always_comb begin
    out_rsp.status        = status_r;
    out_rsp.held_count    = CAP_W'(count_r);
    out_rsp.shortest_span = '0;
    out_rsp.longest_span  = '0;
    if (count_r > CNT_W'(1)) begin
      out_rsp.shortest_span = gap_r;
      out_rsp.longest_span  = SPAN_W'(span_full[VALUE_BITS-1:0]);
    end
  end

  assign out_valid = out_valid_r;

  // Checks
  a_one_probe: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vld))
    else $error("more than one probe in the cell chain");

  a_commit_walk: assert property (@(posedge clk) disable iff (!rst_n)
    commit |-> (state_r == S_WALK))
    else $error("probe left the chain outside the walk state");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("fill count beyond depth");

endmodule

`default_nettype wire
